// ===== hw/rtl/i2cseq_pkg.sv =====
// Package for the I2C register transaction sequencer.
// Holds transfer structs, mode and result kind codes, and the result builder.
// No dependencies.
`default_nettype none

package i2cseq_pkg;

    localparam logic [1:0] MODE_BEGIN_WR = 2'd0;
    localparam logic [1:0] MODE_BEGIN_RD = 2'd1;
    localparam logic [1:0] MODE_HOST     = 2'd2;
    localparam logic [1:0] MODE_DONE     = 2'd3;

    localparam logic [2:0] K_START  = 3'd0;
    localparam logic [2:0] K_STOP   = 3'd1;
    localparam logic [2:0] K_WRITE  = 3'd2;
    localparam logic [2:0] K_RDACK  = 3'd3;
    localparam logic [2:0] K_RDNACK = 3'd4;
    localparam logic [2:0] K_HOST   = 3'd5;
    localparam logic [2:0] K_DONE   = 3'd6;
    localparam logic [2:0] K_REFUSE = 3'd7;

    localparam logic [7:0] WR_MASK = 8'hFE;
    localparam logic [7:0] RD_BIT  = 8'h01;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] device_address;
        logic [7:0] register_index;
        logic [7:0] length;
        logic [7:0] data_byte;
        logic       ack_seen;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic       address_acked;
        logic       data_acked;
        logic       last;
    } t_out_item;

    // Results produced by one input transfer.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

    function automatic t_out_item mk_res(input logic [2:0] kind, input logic [7:0] value,
                                         input logic aa, input logic da, input logic lst);
        t_out_item r;
        r.kind          = kind;
        r.byte_value    = value;
        r.address_acked = aa;
        r.data_acked    = da;
        r.last          = lst;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2cseq_core.sv =====
// Transaction state machine: updates sequencing state on each accepted transfer
// and emits up to two results. Depends on i2cseq_pkg.
`default_nettype none

module i2cseq_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire i2cseq_pkg::t_in_item i_item,
    output i2cseq_pkg::t_push        o_push
);
    import i2cseq_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_ADDR, PH_REG, PH_HOST,
        PH_DATA, PH_RESTART, PH_RADDR, PH_READ, PH_STOP
    } t_phase;

    t_phase     r_phase, n_phase;
    logic       r_reading, n_reading;
    logic [6:0] r_held_address, n_held_address;
    logic [7:0] r_held_register, n_held_register;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic       r_addr_ack, n_addr_ack;
    logic       r_data_ack, n_data_ack;

    logic [7:0] wr_addr;
    logic [7:0] rd_addr;
    logic [7:0] bl_dec;
    t_push      push;

    assign wr_addr = {r_held_address, 1'b0} & WR_MASK;
    assign rd_addr = {r_held_address, 1'b0} | RD_BIT;
    assign bl_dec  = r_bytes_left - 8'd1;

    always_comb begin
        n_phase         = r_phase;
        n_reading       = r_reading;
        n_held_address  = r_held_address;
        n_held_register = r_held_register;
        n_bytes_left    = r_bytes_left;
        n_addr_ack      = r_addr_ack;
        n_data_ack      = r_data_ack;
        push.count      = 2'd1;
        push.item0      = mk_res(K_REFUSE, 8'd0, 1'b0, 1'b0, 1'b1);
        push.item1      = mk_res(K_REFUSE, 8'd0, 1'b0, 1'b0, 1'b1);
        case (i_item.mode)
            MODE_BEGIN_WR, MODE_BEGIN_RD: begin
                if (r_phase == PH_IDLE) begin
                    n_reading       = (i_item.mode == MODE_BEGIN_RD);
                    n_held_address  = i_item.device_address;
                    n_held_register = i_item.register_index;
                    n_bytes_left    = i_item.length;
                    n_addr_ack      = 1'b0;
                    n_data_ack      = 1'b0;
                    n_phase         = PH_START;
                    push.item0      = mk_res(K_START, 8'd0, 1'b0, 1'b0, 1'b1);
                end
            end
            MODE_HOST: begin
                if (r_phase == PH_HOST) begin
                    n_bytes_left = bl_dec;
                    n_phase      = PH_DATA;
                    push.item0   = mk_res(K_WRITE, i_item.data_byte, 1'b0, 1'b0, 1'b1);
                end
            end
            default: begin
                unique case (r_phase)
                    PH_START: begin
                        n_phase    = PH_ADDR;
                        push.item0 = mk_res(K_WRITE, wr_addr, 1'b0, 1'b0, 1'b1);
                    end
                    PH_ADDR: begin
                        n_addr_ack = i_item.ack_seen;
                        if (!i_item.ack_seen) begin
                            n_phase    = PH_STOP;
                            push.item0 = mk_res(K_STOP, 8'd0, 1'b0, 1'b0, 1'b1);
                        end else begin
                            n_phase    = PH_REG;
                            push.item0 = mk_res(K_WRITE, r_held_register, 1'b0, 1'b0, 1'b1);
                        end
                    end
                    PH_REG, PH_DATA: begin
                        n_data_ack = i_item.ack_seen;
                        if (r_phase == PH_REG && r_reading) begin
                            n_phase    = PH_RESTART;
                            push.item0 = mk_res(K_START, 8'd0, 1'b0, 1'b0, 1'b1);
                        end else if (r_bytes_left == 8'd0) begin
                            n_phase    = PH_STOP;
                            push.item0 = mk_res(K_STOP, 8'd0, 1'b0, 1'b0, 1'b1);
                        end else begin
                            n_phase    = PH_HOST;
                            push.count = 2'd0;
                        end
                    end
                    PH_RESTART: begin
                        n_phase    = PH_RADDR;
                        push.item0 = mk_res(K_WRITE, rd_addr, 1'b0, 1'b0, 1'b1);
                    end
                    PH_RADDR: begin
                        n_data_ack = i_item.ack_seen;
                        if (r_bytes_left == 8'd0) begin
                            n_phase    = PH_STOP;
                            push.item0 = mk_res(K_STOP, 8'd0, 1'b0, 1'b0, 1'b1);
                        end else begin
                            n_phase    = PH_READ;
                            push.item0 = mk_res((r_bytes_left == 8'd1) ? K_RDNACK : K_RDACK,
                                                8'd0, 1'b0, 1'b0, 1'b1);
                        end
                    end
                    PH_READ: begin
                        n_bytes_left = bl_dec;
                        push.count   = 2'd2;
                        push.item0   = mk_res(K_HOST, i_item.data_byte, 1'b0, 1'b0, 1'b0);
                        if (bl_dec == 8'd0) begin
                            n_phase    = PH_STOP;
                            push.item1 = mk_res(K_STOP, 8'd0, 1'b0, 1'b0, 1'b1);
                        end else begin
                            n_phase    = PH_READ;
                            push.item1 = mk_res((bl_dec == 8'd1) ? K_RDNACK : K_RDACK,
                                                8'd0, 1'b0, 1'b0, 1'b1);
                        end
                    end
                    PH_STOP: begin
                        n_phase    = PH_IDLE;
                        push.item0 = mk_res(K_DONE, 8'd0, r_addr_ack, r_data_ack, 1'b1);
                    end
                    default: begin
                        push.count = 2'd1;
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        o_push       = push;
        o_push.count = i_accept ? push.count : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_reading       <= 1'b0;
            r_held_address  <= 7'd0;
            r_held_register <= 8'd0;
            r_bytes_left    <= 8'd0;
            r_addr_ack      <= 1'b0;
            r_data_ack      <= 1'b0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_reading       <= n_reading;
            r_held_address  <= n_held_address;
            r_held_register <= n_held_register;
            r_bytes_left    <= n_bytes_left;
            r_addr_ack      <= n_addr_ack;
            r_data_ack      <= n_data_ack;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cseq_queue.sv =====
// Four-entry result queue: takes up to two results per cycle, hands out one unless stalled.
// Depends on i2cseq_pkg.
`default_nettype none

module i2cseq_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire i2cseq_pkg::t_push     i_push,
    output logic                       o_full,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output i2cseq_pkg::t_out_item      o_item
);
    import i2cseq_pkg::*;

    t_out_item  r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       pop;
    logic [1:0] wr_next;

    assign o_valid = (r_count != 3'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_full  = (r_count > 3'd2);
    assign pop     = o_valid && !i_stall;
    assign wr_next = r_wr_ptr + 2'd1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push.count;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, i_push.count} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_register_transaction_sequencer.sv =====
// Top level of the I2C register transaction sequencer.
// Depends on i2cseq_pkg, i2cseq_core and i2cseq_queue.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): begin-write and
// begin-read requests, host data bytes and bus engine completions. Output
// channel (o_out_valid / i_out_stall / o_out_item): engine commands (start,
// stop, write byte, read with ack or nack), bytes for the host, done reports
// and refusals. Each input transfer yields zero, one or two results; the
// last one carries the last flag.
//
// An input transfer updates the sequencing state at its accepting edge and
// its results enter the queue at that edge. One input transfer is
// taken every cycle while the four-entry result queue has room for two
// results; results leave at one per cycle unless the receiver stalls. When
// it stalls, the queue fills and o_in_stall rises once fewer than two slots
// remain free. Reset returns the sequencer to idle and empties the queue.
`default_nettype none

module i2c_register_transaction_sequencer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire i2cseq_pkg::t_in_item  i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output i2cseq_pkg::t_out_item      o_out_item
);
    import i2cseq_pkg::*;

    logic  accept;
    logic  full;
    t_push push;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    i2cseq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push)
    );

    i2cseq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for i2c_register_transaction_sequencer.
// Depends on i2cseq_pkg and the sequencer RTL; predicts every bus command and host byte
// from its own copy of the sequencing state and checks them in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cseq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 900;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_ADDR, PH_REG, PH_HOST,
        PH_DATA, PH_RESTART, PH_RADDR, PH_READ, PH_STOP
    } t_phase;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_BEAT, STALL_HEAVY} t_stall_style;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    // predicted sequencer state
    t_phase     seq_phase;
    logic       seq_reading;
    logic [6:0] seq_addr;
    logic [7:0] seq_reg;
    logic [7:0] seq_left;
    logic       seq_addr_ack;
    logic       seq_data_ack;

    t_out_item  pending_cmds[$];
    int         fail_count;
    int         quiet_cycles;
    int         burst_left;
    bit         hold_request;
    bit         stall_release;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    i2c_register_transaction_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    task automatic push_cmd(input logic [2:0] kind, input logic [7:0] value,
                            input logic aa, input logic da, input logic lst);
        t_out_item r;
        r.kind          = kind;
        r.byte_value    = value;
        r.address_acked = aa;
        r.data_acked    = da;
        r.last          = lst;
        pending_cmds.push_back(r);
    endtask

    task automatic queue_next_read();
        if (seq_left == 8'd0) begin
            push_cmd(K_STOP, 8'h00, 1'b0, 1'b0, 1'b1);
            seq_phase = PH_STOP;
        end else begin
            push_cmd((seq_left == 8'd1) ? K_RDNACK : K_RDACK, 8'h00, 1'b0, 1'b0, 1'b1);
            seq_phase = PH_READ;
        end
    endtask

    // Advances the predicted state by one accepted transfer and queues its results.
    task automatic sequence_request(input t_in_item it);
        logic [7:0] wr_addr;
        logic [7:0] rd_addr;
        wr_addr = {seq_addr, 1'b0} & WR_MASK;
        rd_addr = {seq_addr, 1'b0} | RD_BIT;
        case (it.mode)
            MODE_BEGIN_WR, MODE_BEGIN_RD: begin
                if (seq_phase != PH_IDLE) begin
                    push_cmd(K_REFUSE, 8'h00, 1'b0, 1'b0, 1'b1);
                end else begin
                    seq_reading  = (it.mode == MODE_BEGIN_RD);
                    seq_addr     = it.device_address;
                    seq_reg      = it.register_index;
                    seq_left     = it.length;
                    seq_addr_ack = 1'b0;
                    seq_data_ack = 1'b0;
                    seq_phase    = PH_START;
                    push_cmd(K_START, 8'h00, 1'b0, 1'b0, 1'b1);
                end
            end
            MODE_HOST: begin
                if (seq_phase != PH_HOST) begin
                    push_cmd(K_REFUSE, 8'h00, 1'b0, 1'b0, 1'b1);
                end else begin
                    seq_left  = seq_left - 8'd1;
                    seq_phase = PH_DATA;
                    push_cmd(K_WRITE, it.data_byte, 1'b0, 1'b0, 1'b1);
                end
            end
            default: begin
                case (seq_phase)
                    PH_START: begin
                        seq_phase = PH_ADDR;
                        push_cmd(K_WRITE, wr_addr, 1'b0, 1'b0, 1'b1);
                    end
                    PH_ADDR: begin
                        seq_addr_ack = it.ack_seen;
                        if (!it.ack_seen) begin
                            seq_phase = PH_STOP;
                            push_cmd(K_STOP, 8'h00, 1'b0, 1'b0, 1'b1);
                        end else begin
                            seq_phase = PH_REG;
                            push_cmd(K_WRITE, seq_reg, 1'b0, 1'b0, 1'b1);
                        end
                    end
                    PH_REG, PH_DATA: begin
                        seq_data_ack = it.ack_seen;
                        if (seq_phase == PH_REG && seq_reading) begin
                            seq_phase = PH_RESTART;
                            push_cmd(K_START, 8'h00, 1'b0, 1'b0, 1'b1);
                        end else if (seq_left == 8'd0) begin
                            seq_phase = PH_STOP;
                            push_cmd(K_STOP, 8'h00, 1'b0, 1'b0, 1'b1);
                        end else begin
                            seq_phase = PH_HOST;
                        end
                    end
                    PH_RESTART: begin
                        seq_phase = PH_RADDR;
                        push_cmd(K_WRITE, rd_addr, 1'b0, 1'b0, 1'b1);
                    end
                    PH_RADDR: begin
                        seq_data_ack = it.ack_seen;
                        queue_next_read();
                    end
                    PH_READ: begin
                        push_cmd(K_HOST, it.data_byte, 1'b0, 1'b0, 1'b0);
                        seq_left = seq_left - 8'd1;
                        queue_next_read();
                    end
                    PH_STOP: begin
                        seq_phase = PH_IDLE;
                        push_cmd(K_DONE, 8'h00, seq_addr_ack, seq_data_ack, 1'b1);
                    end
                    default: push_cmd(K_REFUSE, 8'h00, 1'b0, 1'b0, 1'b1);
                endcase
            end
        endcase
    endtask

    function automatic t_in_item make_item(input logic [1:0] mode, input logic [6:0] addr,
                                           input logic [7:0] regi, input logic [7:0] len,
                                           input logic [7:0] data, input logic ack);
        t_in_item it;
        it.mode           = mode;
        it.device_address = addr;
        it.register_index = regi;
        it.length         = len;
        it.data_byte      = data;
        it.ack_seen       = ack;
        return it;
    endfunction

    // Mostly the transfer that the current phase calls for; noise_pct of them out of turn.
    function automatic t_in_item pick_item(input int noise_pct, input int nack_pct);
        t_in_item it;
        int       r;
        bit       noisy;
        it = make_item(MODE_DONE, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        noisy = ($urandom_range(0, 99) < noise_pct);
        case (seq_phase)
            PH_IDLE: begin
                if (noisy) begin
                    it.mode = $urandom_range(0, 1) ? MODE_HOST : MODE_DONE;
                end else begin
                    it.mode = $urandom_range(0, 1) ? MODE_BEGIN_RD : MODE_BEGIN_WR;
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        it.length = 8'd0;
                    else if (r < 11)
                        it.length = 8'($urandom_range(9, 255));
                    else
                        it.length = 8'($urandom_range(1, 8));
                end
            end
            PH_HOST: begin
                if (noisy)
                    it.mode = $urandom_range(0, 1) ? MODE_DONE : MODE_BEGIN_WR;
                else
                    it.mode = MODE_HOST;
            end
            default: begin
                if (noisy)
                    it.mode = $urandom_range(0, 1) ? MODE_HOST : MODE_BEGIN_RD;
                if (seq_phase == PH_ADDR)
                    it.ack_seen = ($urandom_range(0, 99) >= nack_pct);
            end
        endcase
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sequence_request(it);
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sender in bursts; some bursts run straight into the next one.
    task automatic offer_item(input t_in_item it);
        send_item(it);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    task automatic complete(input logic ack);
        offer_item(make_item(MODE_DONE, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), ack));
    endtask

    task automatic finish_transaction();
        while (seq_phase != PH_IDLE)
            offer_item(pick_item(0, 0));
    endtask

    task automatic test_directed();
        // one-byte write, refusals while busy, data byte not acked
        offer_item(make_item(MODE_BEGIN_WR, 7'h7F, 8'hFF, 8'd1, 8'h00, 1'b0));
        offer_item(make_item(MODE_BEGIN_RD, 7'h55, 8'hAA, 8'hFF, 8'hFF, 1'b1));
        offer_item(make_item(MODE_HOST, 7'h00, 8'h00, 8'h00, 8'h5A, 1'b0));
        complete(1'b1);
        complete(1'b1);
        complete(1'b1);
        offer_item(make_item(MODE_HOST, 7'h2A, 8'h55, 8'hAA, 8'hFF, 1'b1));
        complete(1'b0);
        complete(1'b1);
        // completion while idle
        offer_item(make_item(MODE_DONE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        // zero-length read, read address not acked
        offer_item(make_item(MODE_BEGIN_RD, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        complete(1'b1);
        complete(1'b1);
        complete(1'b0);
        complete(1'b1);
        complete(1'b0);
        complete(1'b1);
        // address not acked
        offer_item(make_item(MODE_BEGIN_WR, 7'h2A, 8'h3C, 8'd5, 8'h00, 1'b0));
        complete(1'b1);
        complete(1'b0);
        complete(1'b1);
        // zero-length write
        offer_item(make_item(MODE_BEGIN_WR, 7'h01, 8'h00, 8'd0, 8'h00, 1'b0));
        complete(1'b1);
        complete(1'b1);
        complete(1'b1);
        complete(1'b0);
    endtask

    task automatic test_long_transfers();
        finish_transaction();
        offer_item(make_item(MODE_BEGIN_WR, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                             8'd255, 8'h00, 1'b0));
        finish_transaction();
        offer_item(make_item(MODE_BEGIN_RD, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                             8'd255, 8'h00, 1'b0));
        finish_transaction();
    endtask

    task automatic test_random_transactions(input int count);
        repeat (count)
            offer_item(pick_item(6, 15));
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (40)
            send_item(pick_item(6, 15));
    endtask

    task automatic test_drain_pause();
        pause_sender(1);
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (30)
            offer_item(pick_item(6, 15));
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        seq_phase    = PH_IDLE;
        seq_reading  = 1'b0;
        seq_addr     = '0;
        seq_reg      = '0;
        seq_left     = '0;
        seq_addr_ack = 1'b0;
        seq_data_ack = 1'b0;
        burst_left   = $urandom_range(1, 24);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_long_transfers();
        test_random_transactions(RANDOM_ITEMS);
        test_backpressure();
        test_drain_pause();

        in_valid <= 1'b0;
        stall_release = 1'b1;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("i2c_register_transaction_sequencer verification clean");
        else
            $display("i2c_register_transaction_sequencer verification failed");
        $finish;
    end

    // Receiver: changing stall styles plus one long hold-off requested by the back-pressure test.
    initial begin
        int           hold_left;
        int           style_left;
        int           beat;
        t_stall_style stall_style;
        logic         stall_next;
        hold_left   = 0;
        style_left  = 0;
        beat        = 0;
        stall_style = STALL_NONE;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            beat++;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (style_left == 0) begin
                stall_style = t_stall_style'($urandom_range(0, 3));
                style_left  = $urandom_range(32, 256);
            end else begin
                style_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (stall_release) begin
                stall_next = 1'b0;
            end else begin
                case (stall_style)
                    STALL_LIGHT: stall_next = ($urandom_range(0, 99) < 30);
                    STALL_BEAT:  stall_next = ((beat % 5) < 2);
                    STALL_HEAVY: stall_next = ($urandom_range(0, 99) < 75);
                    default:     stall_next = 1'b0;
                endcase
            end
            out_stall <= stall_next;
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected result: kind %0d byte %0h", out_item.kind, out_item.byte_value);
                fail_count++;
            end else begin
                want = pending_cmds.pop_front();
                check_field("kind", 8'(want.kind), 8'(out_item.kind));
                check_field("byte_value", want.byte_value, out_item.byte_value);
                check_field("address_acked", 8'(want.address_acked),
                            8'(out_item.address_acked));
                check_field("data_acked", 8'(want.data_acked), 8'(out_item.data_acked));
                check_field("last", 8'(want.last), 8'(out_item.last));
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("i2c_register_transaction_sequencer verification failed");
            $finish;
        end
    end

endmodule
